// File: src/assert_macros.svh
// Assertion macros shared by the grip monitor RTL.
// Each macro expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DTGM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define DTGM_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// File: src/dtgm_pkg.sv
// Shared types and constants for the dual touch grip monitor.
// No dependencies; used by every module of the block.
package dtgm_pkg;

    localparam int unsigned LevelW = 16;
    localparam int unsigned FracW  = 8;
    localparam int unsigned FiltW  = LevelW + FracW;
    localparam int unsigned AlphaW = 9;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned CfgAddrW = 2;
    localparam int unsigned CfgDataW = 32;
    localparam int unsigned InDataW  = 64;
    localparam int unsigned OutDataW = 104;

    // Configuration register indexes.
    localparam logic [CfgAddrW-1:0] CfgThreshold = 2'd0;
    localparam logic [CfgAddrW-1:0] CfgAlpha     = 2'd1;
    localparam logic [CfgAddrW-1:0] CfgDebounce  = 2'd2;
    localparam logic [CfgAddrW-1:0] CfgTimeout   = 2'd3;

    // Register reset values.
    localparam logic [15:0]       ThresholdReset = 16'd40;
    localparam logic [AlphaW-1:0] AlphaReset     = 9'd64;
    localparam logic [AlphaW-1:0] AlphaOne       = 9'd256;
    localparam logic [15:0]       DebounceReset  = 16'd50;
    localparam logic [TimeW-1:0]  TimeoutReset   = 32'd3000;

    // Grip state codes.
    localparam logic [1:0] GripNone  = 2'd0;
    localparam logic [1:0] GripLeft  = 2'd1;
    localparam logic [1:0] GripRight = 2'd2;
    localparam logic [1:0] GripBoth  = 2'd3;

    typedef struct packed {
        logic             accepted;
        logic [TimeW-1:0] agree_time;
    } deb_state_t;

endpackage

// File: src/dual_touch_grip_monitor.sv
// Channel   Fields (low bit first)                              Handshake
// s_        left_reading, right_reading, now_ms                 s_tvalid / s_tready
// m_        touches, grip_state, state_changed, durations,      m_tvalid / m_tready
//           hands_off_alert, left_level, right_level
// cfg_      register index and data                             cfg_wr_en, no wait
//
// One item per cycle while the output is not stalled: an input register feeds the filter,
// debounce and grip update, whose result lands in the output register.
// m_tvalid rises as the item enters the output register, which a stall can delay.
// Reset is synchronous on aresetn; no clearing pass is needed.
// A stalled output holds the input register, and s_tready drops only then.
// Depends on dtgm_pkg, dtgm_ema, dtgm_debounce and assert_macros.svh.
`include "assert_macros.svh"

module dual_touch_grip_monitor (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // left_reading[15:0], right_reading[31:16], now_ms[63:32]
    input  logic [dtgm_pkg::InDataW-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // left_touched[0], right_touched[1], grip_state[3:2], state_changed[4],
    // touch_duration_ms[36:5], hands_off_duration_ms[68:37], hands_off_alert[69],
    // left_level[85:70], right_level[101:86], zero[103:102]
    output logic [dtgm_pkg::OutDataW-1:0]    m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [dtgm_pkg::CfgAddrW-1:0]    cfg_addr,
    input  logic [dtgm_pkg::CfgDataW-1:0]    cfg_wdata
);

    // Configuration registers
    logic [15:0]                 threshold_reg;
    logic [dtgm_pkg::AlphaW-1:0] alpha_reg;
    logic [15:0]                 debounce_reg;
    logic [dtgm_pkg::TimeW-1:0]  timeout_reg;

    // Input register
    logic                        in_valid_reg;
    logic [dtgm_pkg::LevelW-1:0] in_left_reg;
    logic [dtgm_pkg::LevelW-1:0] in_right_reg;
    logic [dtgm_pkg::TimeW-1:0]  in_now_reg;

    // Monitor state
    logic                        primed_reg;
    logic [dtgm_pkg::FiltW-1:0]  left_filt_reg, left_filt_next;
    logic [dtgm_pkg::FiltW-1:0]  right_filt_reg, right_filt_next;
    dtgm_pkg::deb_state_t        left_deb_reg, left_deb_next;
    dtgm_pkg::deb_state_t        right_deb_reg, right_deb_next;
    logic [1:0]                  grip_reg, grip_next;
    logic [dtgm_pkg::TimeW-1:0]  change_time_reg, change_time_next;
    logic [dtgm_pkg::TimeW-1:0]  on_dur_reg, on_dur_next;
    logic [dtgm_pkg::TimeW-1:0]  off_dur_reg, off_dur_next;
    logic                        changed_next;

    // Output register
    logic                          out_valid_reg;
    logic [dtgm_pkg::OutDataW-1:0] out_data_reg, out_data_next;

    logic                        advance;
    logic [dtgm_pkg::FiltW-1:0]  left_ema, right_ema;
    dtgm_pkg::deb_state_t        left_deb_upd, right_deb_upd;
    logic [dtgm_pkg::FiltW-1:0]  thr_q;
    logic [1:0]                  grip_cand;
    logic [dtgm_pkg::TimeW-1:0]  since_change;
    logic                        alert;

    // Views of the state and of the output register used by the checks below.
    logic [1:0]                  deb_grip;
    logic [63:0]                 out_durations;
    logic                        hands_on_out;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= dtgm_pkg::ThresholdReset;
            alpha_reg     <= dtgm_pkg::AlphaReset;
            debounce_reg  <= dtgm_pkg::DebounceReset;
            timeout_reg   <= dtgm_pkg::TimeoutReset;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                dtgm_pkg::CfgThreshold: threshold_reg <= cfg_wdata[15:0];
                dtgm_pkg::CfgAlpha:     alpha_reg     <= cfg_wdata[dtgm_pkg::AlphaW-1:0];
                dtgm_pkg::CfgDebounce:  debounce_reg  <= cfg_wdata[15:0];
                dtgm_pkg::CfgTimeout:   timeout_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    dtgm_ema u_left_ema (
        .alpha     (alpha_reg),
        .filt      (left_filt_reg),
        .reading   (in_left_reg),
        .filt_next (left_ema)
    );

    dtgm_ema u_right_ema (
        .alpha     (alpha_reg),
        .filt      (right_filt_reg),
        .reading   (in_right_reg),
        .filt_next (right_ema)
    );

    assign thr_q = {threshold_reg, 8'h00};

    dtgm_debounce u_left_deb (
        .raw         (left_ema <= thr_q),
        .cur         (left_deb_reg),
        .now_ms      (in_now_reg),
        .debounce_ms (debounce_reg),
        .nxt         (left_deb_upd)
    );

    dtgm_debounce u_right_deb (
        .raw         (right_ema <= thr_q),
        .cur         (right_deb_reg),
        .now_ms      (in_now_reg),
        .debounce_ms (debounce_reg),
        .nxt         (right_deb_upd)
    );

    always_comb begin
        left_filt_next   = left_ema;
        right_filt_next  = right_ema;
        left_deb_next    = left_deb_upd;
        right_deb_next   = right_deb_upd;
        grip_next        = grip_reg;
        change_time_next = change_time_reg;
        on_dur_next      = on_dur_reg;
        off_dur_next     = off_dur_reg;
        changed_next     = 1'b0;
        grip_cand        = {right_deb_upd.accepted, left_deb_upd.accepted};
        since_change     = in_now_reg - change_time_reg;

        if (!primed_reg) begin
            // The first item only seeds the filters and the change time.
            left_filt_next   = {in_left_reg, 8'h00};
            right_filt_next  = {in_right_reg, 8'h00};
            left_deb_next    = left_deb_reg;
            right_deb_next   = right_deb_reg;
            change_time_next = in_now_reg;
        end else if (grip_cand != grip_reg) begin
            grip_next        = grip_cand;
            change_time_next = in_now_reg;
            on_dur_next      = '0;
            off_dur_next     = '0;
            changed_next     = 1'b1;
        end else if (grip_reg != dtgm_pkg::GripNone) begin
            on_dur_next  = since_change;
            off_dur_next = '0;
        end else begin
            on_dur_next  = '0;
            off_dur_next = since_change;
        end

        alert = (grip_next == dtgm_pkg::GripNone) && (off_dur_next >= timeout_reg);

        out_data_next = {2'b00,
                         right_filt_next[dtgm_pkg::FiltW-1:dtgm_pkg::FracW],
                         left_filt_next[dtgm_pkg::FiltW-1:dtgm_pkg::FracW],
                         alert,
                         off_dur_next,
                         on_dur_next,
                         changed_next,
                         grip_next,
                         right_deb_next.accepted,
                         left_deb_next.accepted};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_left_reg  <= s_tdata[15:0];
            in_right_reg <= s_tdata[31:16];
            in_now_reg   <= s_tdata[63:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg      <= 1'b0;
            left_filt_reg   <= '0;
            right_filt_reg  <= '0;
            left_deb_reg    <= '0;
            right_deb_reg   <= '0;
            grip_reg        <= dtgm_pkg::GripNone;
            change_time_reg <= '0;
            on_dur_reg      <= '0;
            off_dur_reg     <= '0;
        end else if (advance) begin
            primed_reg      <= 1'b1;
            left_filt_reg   <= left_filt_next;
            right_filt_reg  <= right_filt_next;
            left_deb_reg    <= left_deb_next;
            right_deb_reg   <= right_deb_next;
            grip_reg        <= grip_next;
            change_time_reg <= change_time_next;
            on_dur_reg      <= on_dur_next;
            off_dur_reg     <= off_dur_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign deb_grip      = {right_deb_reg.accepted, left_deb_reg.accepted};
    assign out_durations = out_data_reg[68:5];
    assign hands_on_out  = out_data_reg[3:2] != dtgm_pkg::GripNone;

    // The grip state always mirrors the two debounced touches.
    `DTGM_ASSERT(a_grip_matches, grip_reg == deb_grip, "grip state out of step with touches")
    // Once seeded, the monitor stays seeded until reset.
    `DTGM_ASSERT(a_primed_holds, primed_reg |=> primed_reg, "primed flag dropped")
    // A grip change reports both durations as zero.
    `DTGM_ASSERT(a_change_zero_dur, m_tvalid && m_tdata[4] |-> out_durations == '0, "durations set")
    // The alert is only raised with no hands on the bar.
    `DTGM_NEVER(a_alert_no_hands, m_tvalid && m_tdata[69] && hands_on_out, "alert with a hand on")

endmodule

// File: src/dtgm_ema.sv
// One channel of the exponential moving average in unsigned Q16.8.
// Depends on dtgm_pkg.
module dtgm_ema (
    input  logic [dtgm_pkg::AlphaW-1:0] alpha,
    input  logic [dtgm_pkg::FiltW-1:0]  filt,
    input  logic [dtgm_pkg::LevelW-1:0] reading,
    output logic [dtgm_pkg::FiltW-1:0]  filt_next
);

    logic [dtgm_pkg::AlphaW-1:0] a_sat;
    logic [dtgm_pkg::AlphaW-1:0] a_inv;
    logic [24:0]                 new_prod;
    logic [32:0]                 old_prod;
    logic [32:0]                 sum;

    always_comb begin
        a_sat    = (alpha > dtgm_pkg::AlphaOne) ? dtgm_pkg::AlphaOne : alpha;
        a_inv    = dtgm_pkg::AlphaOne - a_sat;
        new_prod = 25'(a_sat) * 25'(reading);
        old_prod = 33'(a_inv) * 33'(filt);
        sum      = {new_prod, 8'h00} + old_prod;
        // The weighted sum never exceeds 0xFFFF00 << 8, so bit 32 stays clear.
        filt_next = sum[31:8];
    end

endmodule

// File: src/dtgm_debounce.sv
// Time debounce of one channel's raw touch decision.
// Depends on dtgm_pkg.
module dtgm_debounce (
    input  logic                       raw,
    input  dtgm_pkg::deb_state_t       cur,
    input  logic [dtgm_pkg::TimeW-1:0] now_ms,
    input  logic [15:0]                debounce_ms,
    output dtgm_pkg::deb_state_t       nxt
);

    logic [dtgm_pkg::TimeW-1:0] elapsed;

    always_comb begin
        elapsed = now_ms - cur.agree_time;
        nxt     = cur;
        if (raw != cur.accepted) begin
            // Take the new decision once it has disagreed long enough.
            if (elapsed >= {16'h0000, debounce_ms}) begin
                nxt.accepted   = raw;
                nxt.agree_time = now_ms;
            end
        end else begin
            nxt.agree_time = now_ms;
        end
    end

endmodule

// File: sim/dual_touch_grip_monitor_tb.sv
// Self-checking testbench for dual_touch_grip_monitor: a directed table, then random grip
// sequences under several register settings, checked against typed rows or a predictor.
// Depends on dtgm_pkg and the RTL of the block only.
module dual_touch_grip_monitor_tb;

    localparam int unsigned CycleLimit = 600000;
    localparam int unsigned PhaseItems = 165;

    // Field layout of s_tdata, lowest bits last.
    typedef struct packed {
        logic [31:0] now_ms;
        logic [15:0] right_reading;
        logic [15:0] left_reading;
    } grip_sample_t;

    // Field layout of m_tdata, lowest bits last.
    typedef struct packed {
        logic [1:0]  zero;
        logic [15:0] right_level;
        logic [15:0] left_level;
        logic        hands_off_alert;
        logic [31:0] hands_off_ms;
        logic [31:0] touch_ms;
        logic        state_changed;
        logic [1:0]  grip_state;
        logic        right_touched;
        logic        left_touched;
    } grip_report_t;

    typedef struct packed {
        bit           typed;
        grip_sample_t smp;
        grip_report_t want;
    } stim_row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [dtgm_pkg::InDataW-1:0]   s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [dtgm_pkg::OutDataW-1:0]  m_tdata;
    logic                           cfg_wr_en = 1'b0;
    logic [dtgm_pkg::CfgAddrW-1:0]  cfg_addr = '0;
    logic [dtgm_pkg::CfgDataW-1:0]  cfg_wdata = '0;

    dual_touch_grip_monitor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // Predictor copy of the registers and the block state.
    logic [15:0]           thr_r = dtgm_pkg::ThresholdReset;
    logic [8:0]            alpha_r = dtgm_pkg::AlphaReset;
    logic [15:0]           deb_r = dtgm_pkg::DebounceReset;
    logic [31:0]           tmo_r = dtgm_pkg::TimeoutReset;
    bit                    primed = 1'b0;
    logic [23:0]           left_filt = '0;
    logic [23:0]           right_filt = '0;
    dtgm_pkg::deb_state_t  left_deb = '0;
    dtgm_pkg::deb_state_t  right_deb = '0;
    logic [1:0]            grip_now = dtgm_pkg::GripNone;
    logic [31:0]           change_ms = '0;
    logic [31:0]           on_ms = '0;
    logic [31:0]           off_ms = '0;

    grip_report_t pending_reports[$];
    int unsigned  mismatches = 0;
    int unsigned  cycles = 0;
    int unsigned  burst_left = 0;
    logic [31:0]  cursor_ms = 32'hFFFF_FF00;
    bit           hand_l = 1'b0;
    bit           hand_r = 1'b0;
    logic [15:0]  stall_pat = 16'hFFFF;
    logic [5:0]   stall_age = '0;

    stim_row_t opening_rows [0:17] = '{
        '{1'b1, '{32'hFFFF_FF00, 16'hFFFF, 16'h0000},
          '{2'b0, 16'hFFFF, 16'h0000, 1'b0, 32'd0, 32'd0, 1'b0, dtgm_pkg::GripNone,
            1'b0, 1'b0}},
        '{1'b0, '{32'hFFFF_FF10, 16'hFFFF, 16'h0000}, '0},
        '{1'b0, '{32'hFFFF_FF50, 16'hFFFF, 16'h0000}, '0},
        '{1'b0, '{32'hFFFF_FF90, 16'h0000, 16'h0000}, '0},
        '{1'b0, '{32'hFFFF_FFF0, 16'h0000, 16'h0000}, '0},
        '{1'b0, '{32'h0000_0020, 16'h0000, 16'h0000}, '0},
        '{1'b0, '{32'h0000_0060, 16'h0000, 16'h0028}, '0},
        '{1'b0, '{32'h0000_00A0, 16'h0029, 16'h0029}, '0},
        '{1'b0, '{32'h0000_00A0, 16'hFFFF, 16'hFFFF}, '0},
        '{1'b0, '{32'h0000_0100, 16'hFFFF, 16'hFFFF}, '0},
        '{1'b0, '{32'h0000_0200, 16'hFFFF, 16'hFFFF}, '0},
        '{1'b0, '{32'h0000_0C00, 16'hFFFF, 16'hFFFF}, '0},
        '{1'b0, '{32'h0000_0D00, 16'hFFFF, 16'hFFFF}, '0},
        '{1'b0, '{32'h0000_1000, 16'hFFFF, 16'hFFFF}, '0},
        '{1'b0, '{32'h8000_0000, 16'h5555, 16'hAAAA}, '0},
        '{1'b0, '{32'hFFFF_FFFF, 16'hAAAA, 16'h5555}, '0},
        '{1'b0, '{32'h7FFF_FFFF, 16'h0000, 16'h0000}, '0},
        '{1'b0, '{32'h8000_0020, 16'h0000, 16'h0000}, '0}
    };

    function automatic logic [23:0] smooth(logic [23:0] f, logic [15:0] reading);
        logic [63:0] a;
        logic [63:0] sum;
        a = (alpha_r > dtgm_pkg::AlphaOne) ? 64'(dtgm_pkg::AlphaOne) : 64'(alpha_r);
        sum = a * {40'd0, reading, 8'd0} + (64'd256 - a) * {40'd0, f};
        return sum[31:8];
    endfunction

    function automatic dtgm_pkg::deb_state_t settle(dtgm_pkg::deb_state_t s, logic raw,
                                                    logic [31:0] now);
        dtgm_pkg::deb_state_t n;
        logic [31:0]          elapsed;
        n = s;
        elapsed = now - s.agree_time;
        if (raw != s.accepted) begin
            if (elapsed >= {16'd0, deb_r}) begin
                n.accepted = raw;
                n.agree_time = now;
            end
        end else begin
            n.agree_time = now;
        end
        return n;
    endfunction

    function automatic grip_report_t advance_monitor(grip_sample_t smp);
        grip_report_t rep;
        logic [23:0]  thr_q;
        logic [1:0]   next_grip;
        rep = '0;
        if (!primed) begin
            // The first item after reset only loads the filters and the change time.
            left_filt = {smp.left_reading, 8'd0};
            right_filt = {smp.right_reading, 8'd0};
            change_ms = smp.now_ms;
            primed = 1'b1;
        end else begin
            thr_q = {thr_r, 8'd0};
            left_filt = smooth(left_filt, smp.left_reading);
            right_filt = smooth(right_filt, smp.right_reading);
            left_deb = settle(left_deb, left_filt <= thr_q, smp.now_ms);
            right_deb = settle(right_deb, right_filt <= thr_q, smp.now_ms);
            next_grip = {right_deb.accepted, left_deb.accepted};
            if (next_grip != grip_now) begin
                grip_now = next_grip;
                change_ms = smp.now_ms;
                on_ms = '0;
                off_ms = '0;
                rep.state_changed = 1'b1;
            end else if (grip_now != dtgm_pkg::GripNone) begin
                on_ms = smp.now_ms - change_ms;
                off_ms = '0;
            end else begin
                off_ms = smp.now_ms - change_ms;
                on_ms = '0;
            end
        end
        rep.left_touched = left_deb.accepted;
        rep.right_touched = right_deb.accepted;
        rep.grip_state = grip_now;
        rep.touch_ms = on_ms;
        rep.hands_off_ms = off_ms;
        rep.hands_off_alert = (grip_now == dtgm_pkg::GripNone) && (off_ms >= tmo_r);
        rep.left_level = left_filt[23:8];
        rep.right_level = right_filt[23:8];
        return rep;
    endfunction

    function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        grip_report_t got;
        grip_report_t want;
        bit           ok;
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("dual_touch_grip_monitor_tb: FAIL");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = grip_report_t'(m_tdata);
            if (pending_reports.size() == 0) begin
                $display("%0t: result with none expected, actual %0h", $time, m_tdata);
                mismatches <= mismatches + 1;
            end else begin
                want = pending_reports.pop_front();
                ok = field_ok("left_touched", 32'(want.left_touched), 32'(got.left_touched));
                ok &= field_ok("right_touched", 32'(want.right_touched),
                               32'(got.right_touched));
                ok &= field_ok("grip_state", 32'(want.grip_state), 32'(got.grip_state));
                ok &= field_ok("state_changed", 32'(want.state_changed),
                               32'(got.state_changed));
                ok &= field_ok("touch_duration_ms", want.touch_ms, got.touch_ms);
                ok &= field_ok("hands_off_duration_ms", want.hands_off_ms, got.hands_off_ms);
                ok &= field_ok("hands_off_alert", 32'(want.hands_off_alert),
                               32'(got.hands_off_alert));
                ok &= field_ok("left_level", 32'(want.left_level), 32'(got.left_level));
                ok &= field_ok("right_level", 32'(want.right_level), 32'(got.right_level));
                if (!ok) mismatches <= mismatches + 1;
            end
        end
    end

    // The result side stalls on a 16-bit pattern that is redrawn whenever the 6-bit age counter wraps.
    always @(negedge aclk) begin
        if (stall_age == 0) begin
            stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end
        m_tready <= stall_pat[stall_age[3:0]];
        stall_age <= stall_age + 1;
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(grip_sample_t smp, bit typed, grip_report_t want);
        grip_report_t rep;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        rep = advance_monitor(smp);
        pending_reports.push_back(typed ? want : rep);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(logic [dtgm_pkg::CfgAddrW-1:0] addr, logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
    endtask

    task automatic program_monitor(logic [15:0] thr, logic [8:0] alpha, logic [15:0] deb,
                                   logic [31:0] tmo);
        write_reg(dtgm_pkg::CfgThreshold, {16'd0, thr});
        write_reg(dtgm_pkg::CfgAlpha, {23'd0, alpha});
        write_reg(dtgm_pkg::CfgDebounce, {16'd0, deb});
        write_reg(dtgm_pkg::CfgTimeout, tmo);
        cfg_wr_en <= 1'b0;
        thr_r = thr;
        alpha_r = alpha;
        deb_r = deb;
        tmo_r = tmo;
    endtask

    function automatic logic [15:0] level_for(bit on);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return thr_r;
        if (r == 1 || thr_r == 16'hFFFF) return (thr_r == 16'hFFFF) ? thr_r : thr_r + 16'd1;
        if (on) return 16'($urandom_range(0, 32'(thr_r)));
        return 16'($urandom_range(32'(thr_r) + 1, 32'hFFFF));
    endfunction

    // Mostly hands coming and going over a steadily advancing clock, with some noise items.
    task automatic draw_sample(output grip_sample_t smp);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            smp = grip_sample_t'({$urandom, $urandom});
            cursor_ms = smp.now_ms;
        end else begin
            if ($urandom_range(0, 9) == 0) hand_l = !hand_l;
            if ($urandom_range(0, 9) == 0) hand_r = !hand_r;
            r = $urandom_range(0, 99);
            if (r < 75) cursor_ms += $urandom_range(0, 32'(deb_r) * 2 + 10);
            else if (r >= 87) cursor_ms += tmo_r >> $urandom_range(0, 3);
            smp.now_ms = cursor_ms;
            smp.left_reading = level_for(hand_l);
            smp.right_reading = level_for(hand_r);
        end
    endtask

    task automatic run_phase(logic [15:0] thr, logic [8:0] alpha, logic [15:0] deb,
                             logic [31:0] tmo);
        grip_sample_t smp;
        drain_results();
        program_monitor(thr, alpha, deb, tmo);
        repeat (PhaseItems) begin
            draw_sample(smp);
            send_item(smp, 1'b0, '0);
        end
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (opening_rows[i]) begin
            send_item(opening_rows[i].smp, opening_rows[i].typed, opening_rows[i].want);
        end
        run_phase(16'hFFFF, 9'd256, 16'd0, 32'd0);
        run_phase(16'd0, 9'd0, 16'hFFFF, 32'hFFFF_FFFF);
        run_phase(16'd40, 9'd511, 16'd0, 32'd100);
        run_phase(16'd1000, 9'd1, 16'd20, 32'd500);
        repeat (4) begin
            run_phase(($urandom_range(0, 1) == 1) ? 16'($urandom_range(20, 2000))
                                                  : 16'($urandom),
                      9'($urandom_range(0, 511)),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 120)),
                      ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4000));
        end
        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("dual_touch_grip_monitor_tb: PASS");
        end else begin
            $display("dual_touch_grip_monitor_tb: FAIL");
        end
        $finish;
    end

endmodule
